// File: src/m4k_pkg.sv
// Shared types and defaults for the M4' kernel weight pipeline.
// No dependencies; used by every module of the block.
package m4k_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // kernel region of |x|
  typedef enum logic [1:0] {
    BR_INNER,
    BR_OUTER,
    BR_ZERO
  } br_t;

endpackage

// File: src/m4prime_kernel_weight_top.sv
// Top level of the M4' kernel weight block with diffusion correction.
// Holds the input and coefficient registers; uses m4k_pkg, m4k_poly, m4k_diff.
//
//   port group      | direction | flow control
//   in_  / start    | in        | taken when start and not busy
//   out_ / out_valid| out       | one-cycle strobe, no back-pressure
//   cfg_ / cfg_we   | in        | written on cfg_we
//
// One item per cycle. An item passes through six register stages before its result
// strobe rises: input, square, second product, polynomial terms, c^2 product,
// combine and clamp.
// busy is always low: the pipeline has no stall path since the receiver
// cannot hold results off. Synchronous reset clears valids and the coefficient.
module m4prime_kernel_weight_top import m4k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [FRAC_BITS+2:0] in_position,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+4:0] out_weight,
  output logic                        out_saturated,
  input  logic                        cfg_we,
  input  logic        [FRAC_BITS:0]   cfg_diffusion_coef
);

  localparam int F   = FRAC_BITS;
  localparam int CFW = F + 1;
  localparam int CPW = 2 * CFW;
  localparam int CW  = F + 2;
  localparam int TW  = F + 6;
  localparam int WW  = F + 5;
  localparam logic signed [WW-1:0] W_HI = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_LO = {1'b1, {(WW-1){1'b0}}};

  logic                 s0_vld_r;
  logic signed [F+2:0]  s0_pos_r;
  logic [CFW-1:0]       coef_r;
  logic [CPW-1:0]       coef_sq;
  logic [CW-1:0]        c2_nxt;
  logic [CW-1:0]        c2_r;

  logic                 p_vld;
  logic signed [TW-1:0] p_first;
  logic signed [TW-1:0] p_mult;

  assign busy    = 1'b0;
  assign coef_sq = coef_r * coef_r;
  assign c2_nxt  = CW'(coef_sq >> F) + CW'(coef_sq[F-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      coef_r   <= '0;
      c2_r     <= '0;
    end else begin
      s0_vld_r <= start && !busy;
      if (cfg_we) begin
        coef_r <= cfg_diffusion_coef;
      end
      c2_r <= c2_nxt;
    end
    s0_pos_r <= in_position;
  end

  m4k_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s0_vld_r),
    .in_pos    (s0_pos_r),
    .out_vld   (p_vld),
    .out_first (p_first),
    .out_mult  (p_mult)
  );

  m4k_diff #(
    .FRAC_BITS (FRAC_BITS)
  ) u_diff (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (p_vld),
    .in_first   (p_first),
    .in_mult    (p_mult),
    .c2         (c2_r),
    .out_vld    (out_valid),
    .out_weight (out_weight),
    .out_sat    (out_saturated)
  );

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##6 out_valid)
    else $error("item did not come out after six cycles");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching item");

  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_weight == W_HI || out_weight == W_LO))
    else $error("saturated flag with unclamped weight");

endmodule

// File: src/m4k_poly.sv
// Polynomial front end: |x|, region select, square, cube/outer products, terms.
// Three register stages. Depends on m4k_pkg.
module m4k_poly import m4k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [FRAC_BITS+2:0] in_pos,
  output logic                        out_vld,
  output logic signed [FRAC_BITS+5:0] out_first,
  output logic signed [FRAC_BITS+5:0] out_mult
);

  localparam int F   = FRAC_BITS;
  localparam int PW  = F + 3;
  localparam int SW  = F + 1;
  localparam int AW  = F + 1;
  localparam int P1W = 2 * SW;
  localparam int P2W = SW + AW;
  localparam int XW  = P2W + 1;
  localparam int TW  = F + 6;
  localparam logic [PW-1:0] TWO_Q = PW'(1) << (F + 1);

  // stage 1
  logic [PW-1:0]  pos_u;
  logic [PW-1:0]  a_c;
  logic [PW-1:0]  d_full;
  logic [SW-1:0]  b_c;
  br_t            br_c;

  logic           s1_vld_r;
  br_t            s1_br_r;
  logic [AW-1:0]  s1_a_r;
  logic [P1W-1:0] s1_sq_r;

  assign pos_u  = in_pos;
  assign a_c    = pos_u[PW-1] ? (~pos_u + PW'(1)) : pos_u;
  assign d_full = TWO_Q - a_c;

  always_comb begin
    if (a_c[PW-1:F] == '0) begin
      br_c = BR_INNER;
      b_c  = a_c[SW-1:0];
    end else if (a_c[PW-1:F+1] == '0) begin
      br_c = BR_OUTER;
      b_c  = d_full[SW-1:0];
    end else begin
      br_c = BR_ZERO;
      b_c  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_br_r <= br_c;
    s1_a_r  <= a_c[AW-1:0];
    s1_sq_r <= b_c * b_c;
  end

  // stage 2: a2 or d2, then times a
  logic [SW-1:0]  s_c;
  logic           s2_vld_r;
  br_t            s2_br_r;
  logic [SW-1:0]  s2_s_r;
  logic [P2W-1:0] s2_pr_r;

  assign s_c = SW'(s1_sq_r >> F) + SW'(s1_sq_r[F-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_br_r <= s1_br_r;
    s2_s_r  <= s_c;
    s2_pr_r <= s_c * s1_a_r;
  end

  // stage 3: inner P/2 and Q, outer u and v
  logic [SW-1:0]        a3_c;
  logic signed [TW-1:0] a2_t;
  logic signed [TW-1:0] a3_t;
  logic signed [TW-1:0] two_t;
  logic signed [TW-1:0] p_t;
  logic signed [TW-1:0] q_t;
  logic                 p_neg;
  logic [TW-1:0]        p_mag;
  logic [TW-1:0]        h_mag;
  logic signed [TW-1:0] half_t;
  logic [XW-1:0]        dsh;
  logic [XW-1:0]        x_m;
  logic [XW-1:0]        y_m;
  logic [XW-1:0]        u_mag;
  logic [XW-1:0]        v_mag;
  logic signed [TW-1:0] u_t;
  logic signed [TW-1:0] v_t;
  logic signed [TW-1:0] first_c;
  logic signed [TW-1:0] mult_c;

  logic                 s3_vld_r;
  logic signed [TW-1:0] s3_first_r;
  logic signed [TW-1:0] s3_mult_r;

  assign a3_c   = SW'(s2_pr_r >> F) + SW'(s2_pr_r[F-1]);
  assign a2_t   = TW'(s2_s_r);
  assign a3_t   = TW'(a3_c);
  assign two_t  = TW'(1) << (F + 1);
  assign p_t    = two_t - ((a2_t <<< 2) + a2_t) + ((a3_t <<< 1) + a3_t);
  assign q_t    = two_t - ((a2_t <<< 3) + a2_t) + ((a3_t <<< 2) + (a3_t <<< 1));
  assign p_neg  = p_t[TW-1];
  assign p_mag  = p_neg ? -p_t : p_t;
  assign h_mag  = (p_mag >> 1) + TW'(p_mag[0]);
  assign half_t = p_neg ? -$signed(h_mag) : $signed(h_mag);

  assign dsh   = XW'(s2_s_r) << F;
  assign x_m   = XW'(s2_pr_r) - dsh;
  assign y_m   = (XW'(s2_pr_r) << 1) - dsh;
  assign u_mag = (x_m >> (F + 1)) + XW'(x_m[F]);
  assign v_mag = (y_m >> F) + XW'(y_m[F-1]);
  assign u_t   = -$signed(TW'(u_mag));
  assign v_t   = -$signed(TW'(v_mag));

  always_comb begin
    unique case (s2_br_r)
      BR_INNER: begin
        first_c = half_t;
        mult_c  = q_t;
      end
      BR_OUTER: begin
        first_c = u_t;
        mult_c  = v_t;
      end
      default: begin
        first_c = '0;
        mult_c  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_first_r <= first_c;
    s3_mult_r  <= mult_c;
  end

  assign out_vld   = s3_vld_r;
  assign out_first = s3_first_r;
  assign out_mult  = s3_mult_r;

endmodule

// File: src/m4k_diff.sv
// Diffusion correction: c^2 times the second term, subtract, clamp.
// Two register stages. Depends on m4k_pkg.
module m4k_diff import m4k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [FRAC_BITS+5:0] in_first,
  input  logic signed [FRAC_BITS+5:0] in_mult,
  input  logic        [FRAC_BITS+1:0] c2,
  output logic                        out_vld,
  output logic signed [FRAC_BITS+4:0] out_weight,
  output logic                        out_sat
);

  localparam int F   = FRAC_BITS;
  localparam int TW  = F + 6;
  localparam int MG  = F + 4;
  localparam int CW  = F + 2;
  localparam int PRW = CW + MG;
  localparam int RW  = F + 6;
  localparam int EW  = F + 8;
  localparam int WW  = F + 5;
  localparam logic signed [EW-1:0] W_HI = (EW'(1) << (F + 4)) - EW'(1);
  localparam logic signed [EW-1:0] W_LO = -(EW'(1) << (F + 4));

  // stage 4
  logic                 neg_c;
  logic [TW-1:0]        m_abs;
  logic                 s4_vld_r;
  logic                 s4_neg_r;
  logic signed [TW-1:0] s4_first_r;
  logic [PRW-1:0]       s4_prod_r;

  assign neg_c = in_mult[TW-1];
  assign m_abs = neg_c ? -in_mult : in_mult;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= in_vld;
    end
    s4_neg_r   <= neg_c;
    s4_first_r <= in_first;
    s4_prod_r  <= c2 * m_abs[MG-1:0];
  end

  // stage 5
  logic [RW-1:0]        r_c;
  logic signed [EW-1:0] f_ext;
  logic signed [EW-1:0] r_ext;
  logic signed [EW-1:0] w_c;
  logic signed [WW-1:0] weight_nxt;
  logic                 sat_nxt;

  logic                 out_vld_r;
  logic signed [WW-1:0] weight_r;
  logic                 sat_r;

  assign r_c   = RW'(s4_prod_r >> F) + RW'(s4_prod_r[F-1]);
  assign f_ext = EW'(s4_first_r);
  assign r_ext = $signed(EW'(r_c));
  assign w_c   = s4_neg_r ? (f_ext + r_ext) : (f_ext - r_ext);

  always_comb begin
    priority if (w_c > W_HI) begin
      weight_nxt = W_HI[WW-1:0];
      sat_nxt    = 1'b1;
    end else if (w_c < W_LO) begin
      weight_nxt = W_LO[WW-1:0];
      sat_nxt    = 1'b1;
    end else begin
      weight_nxt = w_c[WW-1:0];
      sat_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s4_vld_r;
    end
    weight_r <= weight_nxt;
    sat_r    <= sat_nxt;
  end

  assign out_vld    = out_vld_r;
  assign out_weight = weight_r;
  assign out_sat    = sat_r;

endmodule
